// File: src/aabb_cr_pkg.sv
package aabb_cr_pkg;

    // field widths fixed by the interface
    localparam int COORD_WIDTH = 16;
    localparam int SIZE_WIDTH  = 14;
    localparam int DIR_WIDTH   = 3;
    localparam int ID_WIDTH    = 16;

    // working width for edge sums and differences (coord + size, plus sign headroom)
    localparam int EXT_WIDTH = COORD_WIDTH + 2;

    // hit direction codes
    typedef enum logic [DIR_WIDTH-1:0] {
        DIR_NONE   = 3'd0,
        DIR_TOP    = 3'd1,
        DIR_BOTTOM = 3'd2,
        DIR_LEFT   = 3'd3,
        DIR_RIGHT  = 3'd4
    } dir_t;

    // moving object rectangle
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left;
        logic signed [COORD_WIDTH-1:0] top;
        logic        [SIZE_WIDTH-1:0]  width;
        logic        [SIZE_WIDTH-1:0]  height;
    } obj_t;

    // sign extend a coordinate to the working width
    function automatic logic signed [EXT_WIDTH-1:0] ext_coord(
        input logic signed [COORD_WIDTH-1:0] v
    );
        return {{(EXT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

    // zero extend a size to the working width
    function automatic logic signed [EXT_WIDTH-1:0] ext_size(
        input logic [SIZE_WIDTH-1:0] v
    );
        return $signed({{(EXT_WIDTH-SIZE_WIDTH){1'b0}}, v});
    endfunction

    // clamp a working-width value into the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [EXT_WIDTH-1:0] v
    );
        logic signed [EXT_WIDTH-1:0] max_v;
        logic signed [EXT_WIDTH-1:0] min_v;
        max_v = EXT_WIDTH'((1 <<< (COORD_WIDTH-1)) - 1);
        min_v = -EXT_WIDTH'(1 <<< (COORD_WIDTH-1));
        if (v > max_v) begin
            return COORD_WIDTH'(max_v);
        end else if (v < min_v) begin
            return COORD_WIDTH'(min_v);
        end
        return v[COORD_WIDTH-1:0];
    endfunction

endpackage

// File: src/aabb_cr_classify.sv
module aabb_cr_classify (
    input  aabb_cr_pkg::obj_t                              obj,
    input  logic signed [aabb_cr_pkg::COORD_WIDTH-1:0]     rect_left,
    input  logic signed [aabb_cr_pkg::COORD_WIDTH-1:0]     rect_top,
    input  logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]      rect_width,
    input  logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]      rect_height,
    output aabb_cr_pkg::dir_t                              dir,
    output logic signed [aabb_cr_pkg::COORD_WIDTH-1:0]     new_left,
    output logic signed [aabb_cr_pkg::COORD_WIDTH-1:0]     new_top
);

    logic signed [aabb_cr_pkg::EXT_WIDTH-1:0] ol, ot, orr, ob;
    logic signed [aabb_cr_pkg::EXT_WIDTH-1:0] rl, rt, rr, rb;
    logic signed [aabb_cr_pkg::EXT_WIDTH-1:0] ow, oh;
    logic signed [aabb_cr_pkg::EXT_WIDTH-1:0] pen_left, pen_right, pen_top, pen_bottom;
    logic                                     h_overlap, v_overlap;

    // edges of both rectangles
    always_comb begin
        ol  = aabb_cr_pkg::ext_coord(obj.left);
        ot  = aabb_cr_pkg::ext_coord(obj.top);
        ow  = aabb_cr_pkg::ext_size(obj.width);
        oh  = aabb_cr_pkg::ext_size(obj.height);
        orr = ol + ow;
        ob  = ot + oh;
        rl  = aabb_cr_pkg::ext_coord(rect_left);
        rt  = aabb_cr_pkg::ext_coord(rect_top);
        rr  = rl + aabb_cr_pkg::ext_size(rect_width);
        rb  = rt + aabb_cr_pkg::ext_size(rect_height);
    end

    // penetration depths and axis overlaps
    assign pen_left   = orr - rl;
    assign pen_right  = rr - ol;
    assign pen_top    = ob - rt;
    assign pen_bottom = rb - ot;

    assign h_overlap = (ol <= rl && orr > rl) || (ol < rr && orr >= rr)
                    || (ol >= rl && orr <= rr);
    assign v_overlap = (ot <= rt && ob > rt) || (ot < rb && ob >= rb)
                    || (ot >= rt && ob <= rb);

    // classification: vertical first, side hits yield to a shallower vertical one
    always_comb begin
        dir = aabb_cr_pkg::DIR_NONE;
        if (h_overlap) begin
            if (ot < rt && ob > rt) begin
                dir = aabb_cr_pkg::DIR_TOP;
            end
            if (ot < rb && ob > rb) begin
                dir = aabb_cr_pkg::DIR_BOTTOM;
            end
        end
        if (v_overlap) begin
            if (ol < rl && orr > rl) begin
                if (dir == aabb_cr_pkg::DIR_TOP && pen_top < pen_left) begin
                    dir = aabb_cr_pkg::DIR_TOP;
                end else if (dir == aabb_cr_pkg::DIR_BOTTOM && pen_bottom < pen_left) begin
                    dir = aabb_cr_pkg::DIR_BOTTOM;
                end else begin
                    dir = aabb_cr_pkg::DIR_LEFT;
                end
            end
            if (ol < rr && orr > rr) begin
                if (dir == aabb_cr_pkg::DIR_TOP && pen_top < pen_right) begin
                    dir = aabb_cr_pkg::DIR_TOP;
                end else if (dir == aabb_cr_pkg::DIR_BOTTOM && pen_bottom < pen_right) begin
                    dir = aabb_cr_pkg::DIR_BOTTOM;
                end else begin
                    dir = aabb_cr_pkg::DIR_RIGHT;
                end
            end
        end
    end

    // push-out along the hit direction
    always_comb begin
        new_left = obj.left;
        new_top  = obj.top;
        unique case (dir)
            aabb_cr_pkg::DIR_TOP:    new_top  = aabb_cr_pkg::sat_coord(rt - oh);
            aabb_cr_pkg::DIR_BOTTOM: new_top  = aabb_cr_pkg::sat_coord(rb);
            aabb_cr_pkg::DIR_LEFT:   new_left = aabb_cr_pkg::sat_coord(rl - ow);
            aabb_cr_pkg::DIR_RIGHT:  new_left = aabb_cr_pkg::sat_coord(rr);
            default: ;
        endcase
    end

endmodule

// File: src/aabb_cr_collision_resolver_unit.sv
// aabb_collision_resolver_unit: one moving object is pushed out of a stream of
// reference rectangles. A load transaction (mode 0) sets the object rectangle
// and clears the last-hit record; a test transaction (mode 1) checks one
// reference rectangle, reports the hit direction, and moves the object, which
// the next transaction sees. Every transaction yields exactly one result.
// Throughput is one transaction per cycle while the result side keeps m_ready high;
// the result passes through the input register, then classify and push-out logic into
// the result register, which also updates the object state.
module aabb_collision_resolver_unit #(
    parameter int ID_WIDTH = aabb_cr_pkg::ID_WIDTH
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_mode,
    input  logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] s_rect_left,
    input  logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] s_rect_top,
    input  logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  s_rect_width,
    input  logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  s_rect_height,
    input  logic        [ID_WIDTH-1:0]                 s_ref_id,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic        [aabb_cr_pkg::DIR_WIDTH-1:0]   m_hit_direction,
    output logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] m_obj_left_out,
    output logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] m_obj_top_out,
    output logic        [aabb_cr_pkg::DIR_WIDTH-1:0]   m_last_direction,
    output logic        [ID_WIDTH-1:0]                 m_last_id
);

    // input register
    logic                                       in_valid_reg;
    logic                                       in_mode_reg;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] in_left_reg;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] in_top_reg;
    logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  in_width_reg;
    logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  in_height_reg;
    logic        [ID_WIDTH-1:0]                 in_id_reg;

    // object state
    aabb_cr_pkg::obj_t obj_reg, obj_next;
    aabb_cr_pkg::dir_t last_dir_reg, last_dir_next;
    logic [ID_WIDTH-1:0] last_id_reg, last_id_next;

    // result register
    logic              out_valid_reg;
    aabb_cr_pkg::dir_t out_dir_reg, out_dir_next;

    aabb_cr_pkg::dir_t                          hit_dir;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] push_left;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] push_top;
    logic                                       advance;

    // a transaction moves on when the result slot is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg   <= s_mode;
            in_left_reg   <= s_rect_left;
            in_top_reg    <= s_rect_top;
            in_width_reg  <= s_rect_width;
            in_height_reg <= s_rect_height;
            in_id_reg     <= s_ref_id;
        end
    end

    aabb_cr_classify u_classify (
        .obj         (obj_reg),
        .rect_left   (in_left_reg),
        .rect_top    (in_top_reg),
        .rect_width  (in_width_reg),
        .rect_height (in_height_reg),
        .dir         (hit_dir),
        .new_left    (push_left),
        .new_top     (push_top)
    );

    // next object state and result direction
    always_comb begin
        obj_next      = obj_reg;
        last_dir_next = last_dir_reg;
        last_id_next  = last_id_reg;
        out_dir_next  = aabb_cr_pkg::DIR_NONE;
        if (!in_mode_reg) begin
            obj_next.left   = in_left_reg;
            obj_next.top    = in_top_reg;
            obj_next.width  = in_width_reg;
            obj_next.height = in_height_reg;
            last_dir_next   = aabb_cr_pkg::DIR_NONE;
            last_id_next    = '0;
        end else begin
            obj_next.left = push_left;
            obj_next.top  = push_top;
            out_dir_next  = hit_dir;
            if (hit_dir != aabb_cr_pkg::DIR_NONE) begin
                last_dir_next = hit_dir;
                last_id_next  = in_id_reg;
            end
        end
    end

    // object state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obj_reg      <= '0;
            last_dir_reg <= aabb_cr_pkg::DIR_NONE;
            last_id_reg  <= '0;
        end else if (advance) begin
            obj_reg      <= obj_next;
            last_dir_reg <= last_dir_next;
            last_id_reg  <= last_id_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_dir_reg <= out_dir_next;
        end
    end

    // outputs: position and last-hit record come straight from the state
    assign m_valid          = out_valid_reg;
    assign m_hit_direction  = out_dir_reg;
    assign m_obj_left_out   = obj_reg.left;
    assign m_obj_top_out    = obj_reg.top;
    assign m_last_direction = last_dir_reg;
    assign m_last_id        = last_id_reg;

endmodule

// File: sim/tb_aabb_collision_resolver_unit.sv
`timescale 1ns / 1ps

module tb_aabb_collision_resolver_unit;

    localparam logic MODE_LOAD        = 1'b0;
    localparam logic MODE_TEST        = 1'b1;
    localparam int   IDLE_PERCENT     = 15;
    localparam int   SINK_HOLD_CYCLES = 64;
    localparam int   STALL_LIMIT      = 2000;
    localparam int   MAX_REPORTS      = 10;
    localparam int   DRAIN_CYCLES     = 8;

    // one predicted result transaction
    typedef struct {
        aabb_cr_pkg::dir_t                          hit;
        logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] left;
        logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] top;
        aabb_cr_pkg::dir_t                          last_dir;
        logic        [aabb_cr_pkg::ID_WIDTH-1:0]    last_id;
    } collision_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                                       s_valid       = 1'b0;
    logic                                       s_ready;
    logic                                       s_mode        = MODE_LOAD;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] s_rect_left   = '0;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] s_rect_top    = '0;
    logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  s_rect_width  = '0;
    logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  s_rect_height = '0;
    logic        [aabb_cr_pkg::ID_WIDTH-1:0]    s_ref_id      = '0;
    logic                                       m_valid;
    logic                                       m_ready       = 1'b0;
    logic        [aabb_cr_pkg::DIR_WIDTH-1:0]   m_hit_direction;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] m_obj_left_out;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] m_obj_top_out;
    logic        [aabb_cr_pkg::DIR_WIDTH-1:0]   m_last_direction;
    logic        [aabb_cr_pkg::ID_WIDTH-1:0]    m_last_id;

    // tracked object and last-hit record, as seen after every accepted transaction
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] tracked_left     = '0;
    logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] tracked_top      = '0;
    logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  tracked_width    = '0;
    logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  tracked_height   = '0;
    aabb_cr_pkg::dir_t                          tracked_last_dir = aabb_cr_pkg::DIR_NONE;
    logic        [aabb_cr_pkg::ID_WIDTH-1:0]    tracked_last_id  = '0;

    collision_result_t expected_collisions[$];
    int                error_count       = 0;
    int                quiet_cycles      = 0;
    bit                no_idle           = 1'b0;
    bit                sink_hold_request = 1'b0;

    always #6 aclk = ~aclk;

    aabb_collision_resolver_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_rect_left      (s_rect_left),
        .s_rect_top       (s_rect_top),
        .s_rect_width     (s_rect_width),
        .s_rect_height    (s_rect_height),
        .s_ref_id         (s_ref_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit_direction  (m_hit_direction),
        .m_obj_left_out   (m_obj_left_out),
        .m_obj_top_out    (m_obj_top_out),
        .m_last_direction (m_last_direction),
        .m_last_id        (m_last_id)
    );

    // clamp into the signed coordinate range
    function automatic logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] clamp_coord(input int v);
        if (v > 32767) begin
            return 16'sh7fff;
        end else if (v < -32768) begin
            return 16'sh8000;
        end
        return v[aabb_cr_pkg::COORD_WIDTH-1:0];
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // classify the hit, push the object out and update the last-hit record
    function automatic collision_result_t predict_collision(
        input logic                                       mode,
        input logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] left,
        input logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] top,
        input logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  width,
        input logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  height,
        input logic        [aabb_cr_pkg::ID_WIDTH-1:0]    id
    );
        collision_result_t res;
        int   ol, ot, orr, ob, rl, rt, rw, rh, rr, rb, pen;
        aabb_cr_pkg::dir_t d;
        d  = aabb_cr_pkg::DIR_NONE;
        rl = left;
        rt = top;
        rw = width;
        rh = height;
        if (mode == MODE_LOAD) begin
            tracked_left     = left;
            tracked_top      = top;
            tracked_width    = width;
            tracked_height   = height;
            tracked_last_dir = aabb_cr_pkg::DIR_NONE;
            tracked_last_id  = '0;
        end else begin
            ol  = tracked_left;
            ot  = tracked_top;
            orr = ol + int'(tracked_width);
            ob  = ot + int'(tracked_height);
            rr  = rl + rw;
            rb  = rt + rh;
            // horizontal overlap: look at the reference's top and bottom edges
            if ((ol <= rl && orr > rl) || (ol < rr && orr >= rr) ||
                (ol >= rl && orr <= rr)) begin
                if (ot < rt && ob > rt) d = aabb_cr_pkg::DIR_TOP;
                if (ot < rb && ob > rb) d = aabb_cr_pkg::DIR_BOTTOM;
            end
            // vertical overlap: side hits, unless the vertical penetration is smaller
            if ((ot <= rt && ob > rt) || (ot < rb && ob >= rb) ||
                (ot >= rt && ob <= rb)) begin
                if (ol < rl && orr > rl) begin
                    pen = orr - rl;
                    if (d == aabb_cr_pkg::DIR_TOP && ob - rt < pen) d = aabb_cr_pkg::DIR_TOP;
                    else if (d == aabb_cr_pkg::DIR_BOTTOM && rb - ot < pen)
                        d = aabb_cr_pkg::DIR_BOTTOM;
                    else d = aabb_cr_pkg::DIR_LEFT;
                end
                if (ol < rr && orr > rr) begin
                    pen = rr - ol;
                    if (d == aabb_cr_pkg::DIR_TOP && ob - rt < pen) d = aabb_cr_pkg::DIR_TOP;
                    else if (d == aabb_cr_pkg::DIR_BOTTOM && rb - ot < pen)
                        d = aabb_cr_pkg::DIR_BOTTOM;
                    else d = aabb_cr_pkg::DIR_RIGHT;
                end
            end
            // push-out along the chosen direction
            case (d)
                aabb_cr_pkg::DIR_TOP:    tracked_top  = clamp_coord(rt - int'(tracked_height));
                aabb_cr_pkg::DIR_BOTTOM: tracked_top  = clamp_coord(rb);
                aabb_cr_pkg::DIR_LEFT:   tracked_left = clamp_coord(rl - int'(tracked_width));
                aabb_cr_pkg::DIR_RIGHT:  tracked_left = clamp_coord(rr);
                default: ;
            endcase
            if (d != aabb_cr_pkg::DIR_NONE) begin
                tracked_last_dir = d;
                tracked_last_id  = id;
            end
        end
        res.hit      = d;
        res.left     = tracked_left;
        res.top      = tracked_top;
        res.last_dir = tracked_last_dir;
        res.last_id  = tracked_last_id;
        return res;
    endfunction

    // offer one transaction, wait for acceptance, then queue its prediction
    task automatic send_rect(
        input logic                                       mode,
        input logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] left,
        input logic signed [aabb_cr_pkg::COORD_WIDTH-1:0] top,
        input logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  width,
        input logic        [aabb_cr_pkg::SIZE_WIDTH-1:0]  height,
        input logic        [aabb_cr_pkg::ID_WIDTH-1:0]    id
    );
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_rect_left   <= left;
        s_rect_top    <= top;
        s_rect_width  <= width;
        s_rect_height <= height;
        s_ref_id      <= id;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        expected_collisions.push_back(predict_collision(mode, left, top, width, height, id));
    endtask

    // loads and tests; most tests land near the current object so that hits happen
    task automatic send_random_items(input int count);
        int n, rw, rh, rl, rt;
        bit loaded;
        loaded = 1'b0;
        for (n = 0; n < count; n++) begin
            if (!loaded || $urandom_range(9) == 0) begin
                if ($urandom_range(7) == 0) begin
                    send_rect(MODE_LOAD, 16'($urandom), 16'($urandom), 14'($urandom),
                              14'($urandom), 16'($urandom));
                end else begin
                    rw = ($urandom_range(15) == 0) ? 16383 : rand_between(0, 800);
                    rh = ($urandom_range(15) == 0) ? 16383 : rand_between(0, 800);
                    send_rect(MODE_LOAD, clamp_coord(rand_between(-4000, 4000)),
                              clamp_coord(rand_between(-4000, 4000)), 14'(rw), 14'(rh),
                              16'($urandom));
                end
                loaded = 1'b1;
            end else if ($urandom_range(4) == 0) begin
                // noise: any mode, any fields
                send_rect(1'($urandom), 16'($urandom), 16'($urandom), 14'($urandom),
                          14'($urandom), 16'($urandom));
            end else begin
                rw = ($urandom_range(19) == 0) ? 16383 : rand_between(0, 800);
                rh = ($urandom_range(19) == 0) ? 16383 : rand_between(0, 800);
                rl = int'(tracked_left) + rand_between(-(rw + 32), int'(tracked_width) + 32);
                rt = int'(tracked_top) + rand_between(-(rh + 32), int'(tracked_height) + 32);
                send_rect(MODE_TEST, clamp_coord(rl), clamp_coord(rt), 14'(rw), 14'(rh),
                          16'($urandom));
            end
        end
    endtask

    // test against the zero-size object left by reset
    task automatic test_reset_state();
        send_rect(MODE_TEST, 16'sd0, 16'sd0, 14'd16, 14'd16, 16'h0001);
    endtask

    // each hit direction, the corner rules and a plain miss
    task automatic test_hit_directions();
        // top edge of the reference
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd0, 16'sd200, 14'd256, 14'd256, 16'h0011);
        // bottom edge
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd0, -16'sd200, 14'd256, 14'd256, 16'h0022);
        // left edge
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd200, 16'sd0, 14'd256, 14'd256, 16'h0033);
        // right edge
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, -16'sd200, 16'sd0, 14'd256, 14'd256, 16'h0044);
        // corner with shallow vertical penetration keeps top
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd200, 16'sd240, 14'd256, 14'd256, 16'h0055);
        // corner with shallow horizontal penetration becomes a side hit
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd240, 16'sd200, 14'd256, 14'd256, 16'hffff);
        // reference inside the object's rows: bottom wins over top, id zero
        send_rect(MODE_LOAD, 16'sd0, 16'sd0, 14'd256, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd0, 16'sd100, 14'd256, 14'd50, 16'h0000);
        // touching edges only: no hit, last hit kept
        send_rect(MODE_TEST, 16'sd256, 16'sd150, 14'd256, 14'd256, 16'h0066);
    endtask

    // push-out beyond the coordinate range in all four directions
    task automatic test_push_saturation();
        send_rect(MODE_LOAD, -16'sd32000, 16'sd0, 14'd16383, 14'd256, 16'h0000);
        send_rect(MODE_TEST, -16'sd30000, 16'sd0, 14'd16383, 14'd256, 16'h0101);
        send_rect(MODE_LOAD, 16'sd20000, 16'sd0, 14'd16383, 14'd256, 16'h0000);
        send_rect(MODE_TEST, 16'sd18000, 16'sd0, 14'd16383, 14'd256, 16'h0202);
        send_rect(MODE_LOAD, 16'sd0, -16'sd32000, 14'd256, 14'd16383, 16'h0000);
        send_rect(MODE_TEST, 16'sd0, -16'sd30000, 14'd256, 14'd16383, 16'h0303);
        send_rect(MODE_LOAD, 16'sd0, 16'sd20000, 14'd256, 14'd16383, 16'h0000);
        send_rect(MODE_TEST, 16'sd0, 16'sd18000, 14'd256, 14'd16383, 16'h0404);
        // coordinate and size extremes, far apart
        send_rect(MODE_LOAD, 16'sh8000, 16'sh8000, 14'h3fff, 14'h3fff, 16'hffff);
        send_rect(MODE_TEST, 16'sh7fff, 16'sh7fff, 14'h3fff, 14'h3fff, 16'hffff);
    endtask

    task automatic test_random_stream();
        send_random_items(1300);
    endtask

    // result side stalls for a long stretch while transactions keep coming
    task automatic test_output_backpressure();
        sink_hold_request = 1'b1;
        send_random_items(48);
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_drain_pause();
        send_random_items(24);
        s_valid <= 1'b0;
        while (expected_collisions.size() != 0) @(posedge aclk);
        send_random_items(24);
    endtask

    // no idle cycles on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        send_random_items(360);
        no_idle = 1'b0;
    endtask

    // result side ready, with random stalls and one long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        collision_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_collisions.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result: dir %0d left %0d top %0d last %0d id %0d",
                             m_hit_direction, m_obj_left_out, m_obj_top_out,
                             m_last_direction, m_last_id);
                end
            end else begin
                want = expected_collisions.pop_front();
                if (m_hit_direction !== want.hit || m_obj_left_out !== want.left ||
                    m_obj_top_out !== want.top || m_last_direction !== want.last_dir ||
                    m_last_id !== want.last_id) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"mismatch at %0t: expected dir %0d left %0d top %0d ",
                                  "last %0d id %0d"},
                                 $realtime, want.hit, want.left, want.top, want.last_dir,
                                 want.last_id);
                        $display({"                   got dir %0d left %0d top %0d ",
                                  "last %0d id %0d"},
                                 m_hit_direction, m_obj_left_out, m_obj_top_out,
                                 m_last_direction, m_last_id);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // reset, run the tests in turn, drain and report
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_hit_directions();
        test_push_saturation();
        test_random_stream();
        test_output_backpressure();
        test_drain_pause();
        test_back_to_back();
        s_valid <= 1'b0;
        while (expected_collisions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/aabb_cr_pkg.sv
src/aabb_cr_classify.sv
src/aabb_cr_collision_resolver_unit.sv
sim/tb_aabb_collision_resolver_unit.sv
